### sv/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// Used by mhpq_ctrl and the min_heap_priority_queue top level; no dependencies.
`default_nettype none

package mhpq_pkg;

  // Default sizing of the heap.
  localparam int DEFAULT_CAPACITY = 256;
  localparam int DEFAULT_TAG_BITS = 16;

  // Fixed field widths of the request and result items.
  localparam int KEY_W    = 10;
  localparam int TAG_IO_W = 16;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 9;

  // Stream bus widths; the data buses are rounded up to whole bytes.
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = STATUS_W;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // One request as seen by the sequencer.
  typedef struct packed {
    logic                req_type;
    logic [KEY_W-1:0]    new_key;
    logic [TAG_IO_W-1:0] new_tag;
  } mhpq_req_t;

  // One result as handed to the output register.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    removed_key;
    logic [TAG_IO_W-1:0] removed_tag;
    logic                head_valid;
    logic [KEY_W-1:0]    head_key;
    logic [TAG_IO_W-1:0] head_tag;
    logic [TOTAL_W-1:0]  entry_total;
  } mhpq_res_t;

endpackage

`default_nettype wire

### sv/mhpq_ram.sv
// Generic RAM with one write port and two registered read ports.
// Holds the heap array; no dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

### sv/mhpq_ctrl.sv
// Sift sequencer of the min-heap priority queue: key comparators stepped over
// the heap levels, the entry count and the cached root. Uses mhpq_pkg and mhpq_ram.
`default_nettype none

module mhpq_ctrl
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int TAG_BITS = DEFAULT_TAG_BITS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire mhpq_req_t req_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output mhpq_res_t      res_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 2;
  localparam int ENT_W = KEY_W + TAG_BITS;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UP   = 3'd1;
  localparam logic [2:0] ST_PUT  = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_DOWN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0]    par_q, par_d;
  logic [ENT_W-1:0]    x_q, x_d;
  logic [ENT_W-1:0]    rem_q, rem_d;
  logic [ENT_W-1:0]    head_q;
  logic [STATUS_W-1:0] status_q, status_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr_a, mem_raddr_b;
  logic [ENT_W-1:0] mem_rdata_a, mem_rdata_b;

  logic [ENT_W-1:0] new_ent;
  logic [KEY_W-1:0] x_key, a_key, b_key, pick_key;
  logic [CH_W-1:0]  lc_c, rc_c, cnt_ext, pick_idx;
  logic             has_l, has_r, pick_right;
  logic [ENT_W-1:0] pick_data;
  logic [IDX_W-1:0] grand_par;

  mhpq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(mem_raddr_a),
    .raddr_b_i(mem_raddr_b),
    .rdata_a_o(mem_rdata_a),
    .rdata_b_o(mem_rdata_b)
  );

  // Entry fields and the child/parent positions around the current hole.
  assign new_ent   = {req_i.new_key, TAG_BITS'(req_i.new_tag)};
  assign x_key     = x_q[ENT_W-1 -: KEY_W];
  assign a_key     = mem_rdata_a[ENT_W-1 -: KEY_W];
  assign b_key     = mem_rdata_b[ENT_W-1 -: KEY_W];
  assign lc_c      = (CH_W'(pos_q) << 1) + CH_W'(1);
  assign rc_c      = lc_c + CH_W'(1);
  assign cnt_ext   = CH_W'(count_q);
  assign has_l     = lc_c < cnt_ext;
  assign has_r     = rc_c < cnt_ext;
  assign grand_par = (par_q - IDX_W'(1)) >> 1;

  // Smaller child; the right one wins a tie.
  assign pick_right = has_r && !(a_key < b_key);
  assign pick_data  = pick_right ? mem_rdata_b : mem_rdata_a;
  assign pick_idx   = pick_right ? rc_c : lc_c;
  assign pick_key   = pick_data[ENT_W-1 -: KEY_W];

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  // Sequencer: one heap level per cycle while sifting.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    par_d       = par_q;
    x_d         = x_q;
    rem_d       = rem_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = x_q;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          rem_d    = '0;
          status_d = STATUS_DONE;
          if (req_i.req_type == REQ_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = ST_DONE;
            end else begin
              x_d     = new_ent;
              pos_d   = IDX_W'(count_q);
              count_d = count_q + CNT_W'(1);
              if (count_q == '0) begin
                // Empty queue: the new entry is the root.
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = new_ent;
                state_d   = ST_DONE;
              end else begin
                par_d       = IDX_W'((count_q - CNT_W'(1)) >> 1);
                mem_raddr_a = IDX_W'((count_q - CNT_W'(1)) >> 1);
                state_d     = ST_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = ST_DONE;
            end else begin
              // The root leaves; fetch the last entry to refill it.
              rem_d       = head_q;
              count_d     = count_q - CNT_W'(1);
              mem_raddr_a = IDX_W'(count_q - CNT_W'(1));
              state_d     = (count_q == CNT_W'(1)) ? ST_DONE : ST_LAST;
            end
          end
        end
      end
      ST_UP: begin
        if (x_key < a_key) begin
          // Parent moves down into the hole.
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_a;
          pos_d     = par_q;
          if (par_q == '0) begin
            state_d = ST_PUT;
          end else begin
            par_d       = grand_par;
            mem_raddr_a = grand_par;
          end
        end else begin
          mem_we  = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_PUT: begin
        mem_we  = 1'b1;
        state_d = ST_DONE;
      end
      ST_LAST: begin
        x_d         = mem_rdata_a;
        pos_d       = '0;
        mem_raddr_a = IDX_W'(1);
        mem_raddr_b = IDX_W'(2);
        state_d     = ST_DOWN;
      end
      ST_DOWN: begin
        if (has_l && (pick_key < x_key)) begin
          // Smaller child moves up into the hole.
          mem_we      = 1'b1;
          mem_wdata   = pick_data;
          pos_d       = IDX_W'(pick_idx);
          mem_raddr_a = IDX_W'((pick_idx << 1) + CH_W'(1));
          mem_raddr_b = IDX_W'((pick_idx << 1) + CH_W'(2));
        end else begin
          mem_we  = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers; the root copy follows every write to position zero.
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    par_q    <= par_d;
    x_q      <= x_d;
    rem_q    <= rem_d;
    status_q <= status_d;
    if (mem_we && (mem_waddr == '0)) begin
      head_q <= mem_wdata;
    end
  end

  // Result fields.
  always_comb begin
    res_o.status      = status_q;
    res_o.removed_key = rem_q[ENT_W-1 -: KEY_W];
    res_o.removed_tag = TAG_IO_W'(rem_q[TAG_BITS-1:0]);
    res_o.head_valid  = (count_q != '0);
    res_o.head_key    = '0;
    res_o.head_tag    = '0;
    if (count_q != '0) begin
      res_o.head_key = head_q[ENT_W-1 -: KEY_W];
      res_o.head_tag = TAG_IO_W'(head_q[TAG_BITS-1:0]);
    end
    res_o.entry_total = TOTAL_W'(count_q);
  end

endmodule

`default_nettype wire

### sv/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: stream ports and the result register.
// Depends on mhpq_pkg and mhpq_ctrl.
`default_nettype none

// Binary min-heap priority queue holding up to CAPACITY entries of a 10-bit key and
// a tag. A request with tuser 0 inserts {key, tag}; tuser 1 removes the entry with
// the smallest key. Each request yields exactly one result carrying a status, the
// removed entry (zero if none), the new head and the entry count. An insert into an
// empty queue writes the root directly; a remove of the last entry and a refused
// request go straight to the result; other inserts sift up and other removes fetch
// the last entry and sift down. The sift loop's key comparators and two-read-port
// heap RAM with registered reads handle one heap level per cycle. The input is not
// ready while a request is in work; a finished result waits in the output register
// so the next request can be taken meanwhile.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int TAG_BITS = DEFAULT_TAG_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: new_key[9:0], new_tag[25:10], zero fill [31:26]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: removed_key[9:0], removed_tag[25:10], head_valid[26], head_key[36:27],
  //        head_tag[52:37], entry_total[61:53], zero fill [63:62]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic      [OUT_USER_W-1:0] m_axis_tuser
);

  mhpq_req_t req;
  mhpq_res_t res;
  mhpq_res_t out_q;
  logic      res_valid, res_ready;
  logic      out_valid_q;

  // Unpack the request.
  assign req.req_type = s_axis_tuser[0];
  assign req.new_key  = s_axis_tdata[KEY_W-1:0];
  assign req.new_tag  = s_axis_tdata[KEY_W +: TAG_IO_W];

  mhpq_ctrl #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // The output register takes a new result once the previous one has gone.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // Pack the result.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {2'b00, out_q.entry_total, out_q.head_tag, out_q.head_key,
                          out_q.head_valid, out_q.removed_tag, out_q.removed_key};

endmodule

`default_nettype wire

### tb/mhpq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the min-heap priority queue: watches both stream channels,
// keeps its own heap image to predict each result, and compares field by field.
// Depends on mhpq_pkg for field widths, request kinds and status codes.

module mhpq_result_checker
  import mhpq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  // tdata: new_key[9:0], new_tag[25:10], zero fill [31:26]
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,
  // tuser: req_type[0]
  input  wire logic [IN_USER_W-1:0]  s_tuser_i,
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  // tdata: removed_key[9:0], removed_tag[25:10], head_valid[26], head_key[36:27],
  //        head_tag[52:37], entry_total[61:53], zero fill [63:62]
  input  wire logic [OUT_DATA_W-1:0] m_tdata_i,
  // tuser: status[1:0]
  input  wire logic [OUT_USER_W-1:0] m_tuser_i,
  output int                         mismatch_count_o,
  output int                         pending_count_o
);

  // Heap image kept alongside the block.
  logic [KEY_W-1:0]    heap_key_img [DEFAULT_CAPACITY];
  logic [TAG_IO_W-1:0] heap_tag_img [DEFAULT_CAPACITY];
  int                  held_entries;

  // Results predicted for accepted requests, oldest first.
  mhpq_res_t           awaited_results [$];
  mhpq_res_t           predicted;
  mhpq_res_t           observed;
  mhpq_res_t           oldest;

  // Exchange two heap slots.
  task automatic swap_entries(input int a, input int b);
    logic [KEY_W-1:0]    k;
    logic [TAG_IO_W-1:0] t;
    k = heap_key_img[a];
    t = heap_tag_img[a];
    heap_key_img[a] = heap_key_img[b];
    heap_tag_img[a] = heap_tag_img[b];
    heap_key_img[b] = k;
    heap_tag_img[b] = t;
  endtask

  // Apply one request to the heap image and work out the result it yields.
  task automatic serve_request(input logic req, input logic [KEY_W-1:0] key,
                               input logic [TAG_IO_W-1:0] tag, output mhpq_res_t res);
    int  pos;
    int  parent;
    int  lc;
    int  rc;
    int  pick;
    bit  walking;
    res = '0;
    res.status = STATUS_DONE;
    if (req == REQ_INSERT) begin
      if (held_entries >= DEFAULT_CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        heap_key_img[held_entries] = key;
        heap_tag_img[held_entries] = tag;
        pos = held_entries;
        held_entries++;
        // Sift up while strictly below the parent.
        walking = 1'b1;
        while (walking && pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_key_img[pos] < heap_key_img[parent]) begin
            swap_entries(pos, parent);
            pos = parent;
          end else begin
            walking = 1'b0;
          end
        end
      end
    end else begin
      if (held_entries == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.removed_key = heap_key_img[0];
        res.removed_tag = heap_tag_img[0];
        held_entries--;
        heap_key_img[0] = heap_key_img[held_entries];
        heap_tag_img[0] = heap_tag_img[held_entries];
        // Sift down; on equal children the right one is taken.
        pos = 0;
        walking = 1'b1;
        while (walking) begin
          lc = pos * 2 + 1;
          rc = pos * 2 + 2;
          if (rc < held_entries) begin
            pick = (heap_key_img[lc] < heap_key_img[rc]) ? lc : rc;
          end else if (lc < held_entries) begin
            pick = lc;
          end else begin
            pick = -1;
          end
          if (pick >= 0 && heap_key_img[pick] < heap_key_img[pos]) begin
            swap_entries(pick, pos);
            pos = pick;
          end else begin
            walking = 1'b0;
          end
        end
      end
    end
    if (held_entries > 0) begin
      res.head_valid = 1'b1;
      res.head_key   = heap_key_img[0];
      res.head_tag   = heap_tag_img[0];
    end
    res.entry_total = TOTAL_W'(held_entries);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  // Check results first, then record the request taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_entries     = 0;
      mismatch_count_o = 0;
      awaited_results.delete();
      pending_count_o  = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        observed             = '0;
        observed.status      = m_tuser_i[STATUS_W-1:0];
        observed.removed_key = m_tdata_i[9:0];
        observed.removed_tag = m_tdata_i[25:10];
        observed.head_valid  = m_tdata_i[26];
        observed.head_key    = m_tdata_i[36:27];
        observed.head_tag    = m_tdata_i[52:37];
        observed.entry_total = m_tdata_i[61:53];
        if (awaited_results.size() == 0) begin
          $error("result delivered with no request waiting for one");
          mismatch_count_o++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("status", oldest.status, observed.status);
          compare_field("removed_key", oldest.removed_key, observed.removed_key);
          compare_field("removed_tag", oldest.removed_tag, observed.removed_tag);
          compare_field("head_valid", oldest.head_valid, observed.head_valid);
          compare_field("head_key", oldest.head_key, observed.head_key);
          compare_field("head_tag", oldest.head_tag, observed.head_tag);
          compare_field("entry_total", oldest.entry_total, observed.entry_total);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        serve_request(s_tuser_i[0], s_tdata_i[9:0], s_tdata_i[25:10], predicted);
        awaited_results.push_back(predicted);
      end
      pending_count_o = awaited_results.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the min-heap priority queue testbench: clock, reset, request stimulus,
// receiver back-pressure, watchdog and verdict. Depends on mhpq_pkg,
// min_heap_priority_queue and mhpq_result_checker.

module tb_top;
  import mhpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  int  mismatch_count;
  int  pending_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  quiet_cycles;
  bit  long_hold_go;

  min_heap_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mhpq_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog: count cycles in which neither channel moves anything.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("min_heap_priority_queue regression: fail");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on demand.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
                              input logic [TAG_IO_W-1:0] tag);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({tag, key});
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Keys lean toward the extremes and a narrow band that produces many ties.
  function automatic logic [KEY_W-1:0] random_key();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) begin
      case ($urandom_range(2))
        0:       return KEY_W'(0);
        1:       return KEY_W'(1000);
        default: return KEY_W'(1023);
      endcase
    end else if (sel <= 2) begin
      return KEY_W'($urandom_range(7));
    end
    return KEY_W'($urandom_range(1023));
  endfunction

  // A run of random requests, inserting with the given likelihood.
  task automatic send_mix(input int n, input int insert_pct);
    logic req;
    for (int i = 0; i < n; i++) begin
      req = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      send_request(req, random_key(), TAG_IO_W'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_idle_pct = 12;
    recv_idle_pct = 73;
    long_hold_go  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: remove from empty, key and tag extremes, keys above 1000,
    // equal keys on the way up and on the way down, and a drain past empty.
    send_request(REQ_REMOVE, KEY_W'(1023), 16'hFFFF);
    send_request(REQ_INSERT, KEY_W'(500), 16'h1234);
    send_request(REQ_INSERT, KEY_W'(1000), 16'hFFFF);
    send_request(REQ_INSERT, KEY_W'(0), 16'h0000);
    send_request(REQ_INSERT, KEY_W'(1023), 16'hAAAA);
    send_request(REQ_INSERT, KEY_W'(0), 16'h5555);
    send_request(REQ_INSERT, KEY_W'(500), 16'h0F0F);
    send_request(REQ_INSERT, KEY_W'(1023), 16'hFFFF);
    repeat (8) send_request(REQ_REMOVE, KEY_W'(0), 16'h0000);
    send_request(REQ_INSERT, KEY_W'(5), 16'h000A);
    send_request(REQ_INSERT, KEY_W'(5), 16'h000B);
    send_request(REQ_INSERT, KEY_W'(5), 16'h000C);
    send_request(REQ_INSERT, KEY_W'(5), 16'h000D);
    repeat (4) send_request(REQ_REMOVE, KEY_W'(0), 16'h0000);

    // Random mix with the sender mostly busy and the receiver mostly stalling.
    send_mix(150, 70);
    send_mix(150, 35);
    send_mix(150, 55);

    // Sender mostly idle, receiver mostly ready: fill past capacity, drain past empty.
    send_idle_pct = 73;
    recv_idle_pct = 12;
    send_mix(262, 100);
    send_mix(262, 0);

    // No idling on either side; one long receiver hold-off while requests keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_mix(20, 80);
    long_hold_go = 1'b1;
    send_mix(120, 65);
    send_mix(130, 40);
    send_mix(130, 60);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("min_heap_priority_queue regression: pass");
    end else begin
      $display("min_heap_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

### min_heap_priority_queue.f
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/mhpq_ctrl.sv
sv/min_heap_priority_queue.sv
tb/mhpq_result_checker.sv
tb/tb_top.sv
